### hw/rtl/rcrc_pkg.sv
// Shared types and constants for the RGB color region classifier.
// Holds register indexes, mode codes and the stage records of the pipeline.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package rcrc_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_MODE        = 3'd0;
   localparam logic [2:0] REG_BOX_LOW     = 3'd1;
   localparam logic [2:0] REG_BOX_HIGH    = 3'd2;
   localparam logic [2:0] REG_CENTRE_RGB  = 3'd3;
   localparam logic [2:0] REG_SPHERE_RSQ  = 3'd4;
   localparam logic [2:0] REG_INV_COV_DIAG = 3'd5;
   localparam logic [2:0] REG_INV_COV_OFF = 3'd6;
   localparam logic [2:0] REG_MAHAL_LIMIT = 3'd7;

   // Region modes.
   localparam logic [1:0] MODE_BOX    = 2'd0;
   localparam logic [1:0] MODE_SPHERE = 2'd1;
   localparam logic [1:0] MODE_MAHAL  = 2'd2;

   localparam int CSR_DATA_W = 48;

   // Reset values of the configuration registers.
   localparam logic [23:0] BOX_HIGH_RESET = 24'hFF_FFFF;

   // Stage 1: channel differences from the centre and the box decision.
   typedef struct packed {
      logic              valid;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic              box_hit;
      logic signed [8:0] dr;
      logic signed [8:0] dg;
      logic signed [8:0] db;
   } stage1_type;

   // Stage 2: squares and cross products of the differences.
   typedef struct packed {
      logic               valid;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic               box_hit;
      logic [15:0]        sq_r;
      logic [15:0]        sq_g;
      logic [15:0]        sq_b;
      logic signed [16:0] x_rg;
      logic signed [16:0] x_rb;
      logic signed [16:0] x_gb;
   } stage2_type;

   // Stage 3: weighted terms of the quadratic form and the sphere decision.
   typedef struct packed {
      logic               valid;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic               box_hit;
      logic               sphere_hit;
      logic signed [32:0] t_rr;
      logic signed [32:0] t_gg;
      logic signed [32:0] t_bb;
      logic signed [32:0] t_rg;
      logic signed [32:0] t_rb;
      logic signed [32:0] t_gb;
   } stage3_type;

   // Stage 4: diagonal and off-diagonal partial sums.
   typedef struct packed {
      logic               valid;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic               box_hit;
      logic               sphere_hit;
      logic signed [34:0] diag_sum;
      logic signed [34:0] off_sum;
   } stage4_type;

   // Stage 5: the finished result beat.
   typedef struct packed {
      logic       valid;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       kept;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/rcrc_front.sv
// First pipeline stage: differences from the centre color and box test.
// Depends on rcrc_pkg for the stage record.
`default_nettype none

module rcrc_front
   import rcrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        in_valid,
   input  wire logic [7:0]  red,
   input  wire logic [7:0]  green,
   input  wire logic [7:0]  blue,
   input  wire logic [23:0] box_low,
   input  wire logic [23:0] box_high,
   input  wire logic [23:0] centre_rgb,
   output stage1_type       s1_ff
);

   stage1_type s1_in;
   logic       hit_r;
   logic       hit_g;
   logic       hit_b;

   // Strict box limits per channel.
   assign hit_r = (red   > box_low[23:16]) && (red   < box_high[23:16]);
   assign hit_g = (green > box_low[15:8])  && (green < box_high[15:8]);
   assign hit_b = (blue  > box_low[7:0])   && (blue  < box_high[7:0]);

   // Signed 9-bit differences from the centre.
   always_comb begin
      s1_in.valid   = in_valid;
      s1_in.red     = red;
      s1_in.green   = green;
      s1_in.blue    = blue;
      s1_in.box_hit = hit_r && hit_g && hit_b;
      s1_in.dr      = $signed({1'b0, red})   - $signed({1'b0, centre_rgb[23:16]});
      s1_in.dg      = $signed({1'b0, green}) - $signed({1'b0, centre_rgb[15:8]});
      s1_in.db      = $signed({1'b0, blue})  - $signed({1'b0, centre_rgb[7:0]});
   end

   // Stage register; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/rcrc_mult.sv
// Second and third pipeline stages: products of the differences, then the
// coefficient multiplies and the sphere test. Depends on rcrc_pkg.
`default_nettype none

module rcrc_mult
   import rcrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  stage1_type       s1_ff,
   input  wire logic [17:0] sphere_radius_sq,
   input  wire logic [47:0] inv_cov_diag,
   input  wire logic [47:0] inv_cov_off,
   output stage3_type       s3_ff
);

   stage2_type         s2_in;
   stage2_type         s2_ff;
   stage3_type         s3_in;
   logic        [17:0] sphere_sum;
   logic signed [15:0] c_rr;
   logic signed [15:0] c_gg;
   logic signed [15:0] c_bb;
   logic signed [15:0] c_rg;
   logic signed [15:0] c_rb;
   logic signed [15:0] c_gb;

   // Squares and cross products, one small multiplier each.
   always_comb begin
      s2_in.valid   = s1_ff.valid;
      s2_in.red     = s1_ff.red;
      s2_in.green   = s1_ff.green;
      s2_in.blue    = s1_ff.blue;
      s2_in.box_hit = s1_ff.box_hit;
      s2_in.sq_r    = 16'(unsigned'(18'(s1_ff.dr * s1_ff.dr)));
      s2_in.sq_g    = 16'(unsigned'(18'(s1_ff.dg * s1_ff.dg)));
      s2_in.sq_b    = 16'(unsigned'(18'(s1_ff.db * s1_ff.db)));
      s2_in.x_rg    = 17'(s1_ff.dr * s1_ff.dg);
      s2_in.x_rb    = 17'(s1_ff.dr * s1_ff.db);
      s2_in.x_gb    = 17'(s1_ff.dg * s1_ff.db);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_ff <= s2_in;
      end
   end

   // Unpack the signed inverse covariance terms.
   assign c_rr = $signed(inv_cov_diag[47:32]);
   assign c_gg = $signed(inv_cov_diag[31:16]);
   assign c_bb = $signed(inv_cov_diag[15:0]);
   assign c_rg = $signed(inv_cov_off[47:32]);
   assign c_rb = $signed(inv_cov_off[31:16]);
   assign c_gb = $signed(inv_cov_off[15:0]);

   // Squared distance for the sphere; it fits 18 bits unsigned.
   assign sphere_sum = {2'b00, s2_ff.sq_r} + {2'b00, s2_ff.sq_g} + {2'b00, s2_ff.sq_b};

   // Coefficient times product, 16 by 17 bits signed.
   always_comb begin
      s3_in.valid      = s2_ff.valid;
      s3_in.red        = s2_ff.red;
      s3_in.green      = s2_ff.green;
      s3_in.blue       = s2_ff.blue;
      s3_in.box_hit    = s2_ff.box_hit;
      s3_in.sphere_hit = (sphere_sum <= sphere_radius_sq);
      s3_in.t_rr       = 33'(c_rr * $signed({1'b0, s2_ff.sq_r}));
      s3_in.t_gg       = 33'(c_gg * $signed({1'b0, s2_ff.sq_g}));
      s3_in.t_bb       = 33'(c_bb * $signed({1'b0, s2_ff.sq_b}));
      s3_in.t_rg       = 33'(c_rg * s2_ff.x_rg);
      s3_in.t_rb       = 33'(c_rb * s2_ff.x_rb);
      s3_in.t_gb       = 33'(c_gb * s2_ff.x_gb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_ff <= s3_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/rcrc_accum.sv
// Fourth and fifth pipeline stages: sums the quadratic form, compares it
// with the limit and selects the decision by mode. Depends on rcrc_pkg.
`default_nettype none

module rcrc_accum
   import rcrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  stage3_type       s3_ff,
   input  wire logic [1:0]  mode,
   input  wire logic [39:0] mahal_limit_sq,
   output result_type       res_ff
);

   stage4_type         s4_in;
   stage4_type         s4_ff;
   result_type         res_in;
   logic signed [40:0] k_sum;
   logic signed [40:0] limit_ext;
   logic               mahal_hit;
   logic               keep;

   // Diagonal and off-diagonal partial sums.
   always_comb begin
      s4_in.valid      = s3_ff.valid;
      s4_in.red        = s3_ff.red;
      s4_in.green      = s3_ff.green;
      s4_in.blue       = s3_ff.blue;
      s4_in.box_hit    = s3_ff.box_hit;
      s4_in.sphere_hit = s3_ff.sphere_hit;
      s4_in.diag_sum   = 35'(s3_ff.t_rr) + 35'(s3_ff.t_gg) + 35'(s3_ff.t_bb);
      s4_in.off_sum    = 35'(s3_ff.t_rg) + 35'(s3_ff.t_rb) + 35'(s3_ff.t_gb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff.valid <= 1'b0;
      end else if (advance) begin
         s4_ff <= s4_in;
      end
   end

   // Off-diagonal terms count twice; a negative form is always inside.
   assign k_sum     = 41'(s4_ff.diag_sum) + (41'(s4_ff.off_sum) <<< 1);
   assign limit_ext = $signed({1'b0, mahal_limit_sq});
   assign mahal_hit = (k_sum <= limit_ext);

   // Mode select; the unused mode rejects every pixel.
   always_comb begin
      unique case (mode)
         MODE_BOX:    keep = s4_ff.box_hit;
         MODE_SPHERE: keep = s4_ff.sphere_hit;
         MODE_MAHAL:  keep = mahal_hit;
         default:     keep = 1'b0;
      endcase
   end

   always_comb begin
      res_in.valid     = s4_ff.valid;
      res_in.out_red   = keep ? s4_ff.red   : 8'd0;
      res_in.out_green = keep ? s4_ff.green : 8'd0;
      res_in.out_blue  = keep ? s4_ff.blue  : 8'd0;
      res_in.kept      = keep;
   end

   // Output register that drives the result channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (advance) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/rgb_color_region_classifier_top.sv
// RGB color region classifier: takes one pixel beat per clock and returns it
// unchanged when it lies inside the configured box, sphere or Mahalanobis
// ellipsoid, and blacked out otherwise. A new pixel is accepted in every
// cycle in which the result register is empty or being taken; the five
// register stages (difference, products, coefficient multiplies, partial
// sums, compare) move together and hold as a whole while the result waits.
// Configuration writes take effect at once and must be made while no pixel
// is in flight. Depends on rcrc_pkg, rcrc_front, rcrc_mult and rcrc_accum.
`default_nettype none

module rgb_color_region_classifier_top
   import rcrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_red,
   input  wire logic [7:0]            req_green,
   input  wire logic [7:0]            req_blue,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_out_red,
   output logic [7:0]                 rsp_out_green,
   output logic [7:0]                 rsp_out_blue,
   output logic                       rsp_kept,

   input  wire logic                  csr_we,
   input  wire logic [2:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [1:0]  mode_ff;
   logic [23:0] box_low_ff;
   logic [23:0] box_high_ff;
   logic [23:0] centre_rgb_ff;
   logic [17:0] sphere_radius_sq_ff;
   logic [47:0] inv_cov_diag_ff;
   logic [47:0] inv_cov_off_ff;
   logic [39:0] mahal_limit_sq_ff;

   logic        advance;
   stage1_type  s1_ff;
   stage3_type  s3_ff;
   result_type  res_ff;

   // Configuration registers, masked to their widths.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff             <= MODE_BOX;
         box_low_ff          <= '0;
         box_high_ff         <= BOX_HIGH_RESET;
         centre_rgb_ff       <= '0;
         sphere_radius_sq_ff <= '0;
         inv_cov_diag_ff     <= '0;
         inv_cov_off_ff      <= '0;
         mahal_limit_sq_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MODE:         mode_ff             <= csr_wdata[1:0];
            REG_BOX_LOW:      box_low_ff          <= csr_wdata[23:0];
            REG_BOX_HIGH:     box_high_ff         <= csr_wdata[23:0];
            REG_CENTRE_RGB:   centre_rgb_ff       <= csr_wdata[23:0];
            REG_SPHERE_RSQ:   sphere_radius_sq_ff <= csr_wdata[17:0];
            REG_INV_COV_DIAG: inv_cov_diag_ff     <= csr_wdata[47:0];
            REG_INV_COV_OFF:  inv_cov_off_ff      <= csr_wdata[47:0];
            REG_MAHAL_LIMIT:  mahal_limit_sq_ff   <= csr_wdata[39:0];
            default:          mode_ff             <= mode_ff;
         endcase
      end
   end

   // The whole pipeline moves unless a result beat is waiting.
   assign advance   = !res_ff.valid || rsp_ready;
   assign req_ready = advance;

   rcrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .box_low    (box_low_ff),
      .box_high   (box_high_ff),
      .centre_rgb (centre_rgb_ff),
      .s1_ff      (s1_ff)
   );

   rcrc_mult u_mult (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .s1_ff            (s1_ff),
      .sphere_radius_sq (sphere_radius_sq_ff),
      .inv_cov_diag     (inv_cov_diag_ff),
      .inv_cov_off      (inv_cov_off_ff),
      .s3_ff            (s3_ff)
   );

   rcrc_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .s3_ff          (s3_ff),
      .mode           (mode_ff),
      .mahal_limit_sq (mahal_limit_sq_ff),
      .res_ff         (res_ff)
   );

   // Result channel straight from the output register.
   assign rsp_valid     = res_ff.valid;
   assign rsp_out_red   = res_ff.out_red;
   assign rsp_out_green = res_ff.out_green;
   assign rsp_out_blue  = res_ff.out_blue;
   assign rsp_kept      = res_ff.kept;

endmodule

`default_nettype wire
